/* rtl/datamatrix_symbol_size_select_assert.svh */
// Assertion macros used by the symbol size selection checker.
`ifndef DATAMATRIX_SYMBOL_SIZE_SELECT_ASSERT_SVH
`define DATAMATRIX_SYMBOL_SIZE_SELECT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dss_pkg.sv */
// Types, register codes and the ECC200 symbol size table.
package dss_pkg;

  localparam int IDX_W  = 5;
  localparam int NEED_W = 11;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SHAPE_MODE       = 3'd0;
  localparam logic [2:0] REG_MIN_WIDTH        = 3'd1;
  localparam logic [2:0] REG_MIN_HEIGHT       = 3'd2;
  localparam logic [2:0] REG_MAX_WIDTH        = 3'd3;
  localparam logic [2:0] REG_MAX_HEIGHT       = 3'd4;
  localparam logic [2:0] REG_FAIL_ON_OVERFLOW = 3'd5;

  // Shape mode codes; the unused code behaves as any shape.
  localparam logic [1:0] SHAPE_ANY    = 2'd0;
  localparam logic [1:0] SHAPE_SQUARE = 2'd1;
  localparam logic [1:0] SHAPE_RECT   = 2'd2;

  typedef struct packed {
    logic        rect;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [10:0] data;
    logic [9:0]  ecc;
    logic [4:0]  rw;
    logic [4:0]  rh;
    logic [2:0]  hr;
    logic [2:0]  vr;
    logic [3:0]  blocks;
  } dss_entry_t;

  typedef struct packed {
    logic [1:0] shape;
    logic [7:0] min_w;
    logic [7:0] min_h;
    logic [7:0] max_w;
    logic [7:0] max_h;
  } dss_cfg_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [NEED_W-1:0] need;
  } dss_token_t;

  function automatic dss_entry_t mk_entry(input int rect, input int w, input int h,
                                          input int d, input int e, input int rw,
                                          input int rh, input int hr, input int vr,
                                          input int bl);
    dss_entry_t ent;
    ent.rect   = 1'(rect);
    ent.width  = 8'(w);
    ent.height = 8'(h);
    ent.data   = 11'(d);
    ent.ecc    = 10'(e);
    ent.rw     = 5'(rw);
    ent.rh     = 5'(rh);
    ent.hr     = 3'(hr);
    ent.vr     = 3'(vr);
    ent.blocks = 4'(bl);
    return ent;
  endfunction

  // Full width and height include the finder and clock borders of every region.
  function automatic dss_entry_t dss_entry(input logic [IDX_W-1:0] i);
    dss_entry_t ent;
    case (i)
      5'd0:    ent = mk_entry(0,  10,  10,    3,   5,  8,  8, 1, 1,  1);
      5'd1:    ent = mk_entry(0,  12,  12,    5,   7, 10, 10, 1, 1,  1);
      5'd2:    ent = mk_entry(1,  18,   8,    5,   7, 16,  6, 1, 1,  1);
      5'd3:    ent = mk_entry(0,  14,  14,    8,  10, 12, 12, 1, 1,  1);
      5'd4:    ent = mk_entry(1,  32,   8,   10,  11, 14,  6, 2, 1,  1);
      5'd5:    ent = mk_entry(0,  16,  16,   12,  12, 14, 14, 1, 1,  1);
      5'd6:    ent = mk_entry(1,  26,  12,   16,  14, 24, 10, 1, 1,  1);
      5'd7:    ent = mk_entry(0,  18,  18,   18,  14, 16, 16, 1, 1,  1);
      5'd8:    ent = mk_entry(0,  20,  20,   22,  18, 18, 18, 1, 1,  1);
      5'd9:    ent = mk_entry(1,  36,  12,   22,  18, 16, 10, 2, 1,  1);
      5'd10:   ent = mk_entry(0,  22,  22,   30,  20, 20, 20, 1, 1,  1);
      5'd11:   ent = mk_entry(1,  36,  16,   32,  24, 16, 14, 2, 1,  1);
      5'd12:   ent = mk_entry(0,  24,  24,   36,  24, 22, 22, 1, 1,  1);
      5'd13:   ent = mk_entry(0,  26,  26,   44,  28, 24, 24, 1, 1,  1);
      5'd14:   ent = mk_entry(1,  48,  16,   49,  28, 22, 14, 2, 1,  1);
      5'd15:   ent = mk_entry(0,  32,  32,   62,  36, 14, 14, 2, 2,  1);
      5'd16:   ent = mk_entry(0,  36,  36,   86,  42, 16, 16, 2, 2,  1);
      5'd17:   ent = mk_entry(0,  40,  40,  114,  48, 18, 18, 2, 2,  1);
      5'd18:   ent = mk_entry(0,  44,  44,  144,  56, 20, 20, 2, 2,  1);
      5'd19:   ent = mk_entry(0,  48,  48,  174,  68, 22, 22, 2, 2,  1);
      5'd20:   ent = mk_entry(0,  52,  52,  204,  84, 24, 24, 2, 2,  2);
      5'd21:   ent = mk_entry(0,  64,  64,  280, 112, 14, 14, 4, 4,  2);
      5'd22:   ent = mk_entry(0,  72,  72,  368, 144, 16, 16, 4, 4,  4);
      5'd23:   ent = mk_entry(0,  80,  80,  456, 192, 18, 18, 4, 4,  4);
      5'd24:   ent = mk_entry(0,  88,  88,  576, 224, 20, 20, 4, 4,  4);
      5'd25:   ent = mk_entry(0,  96,  96,  696, 272, 22, 22, 4, 4,  4);
      5'd26:   ent = mk_entry(0, 104, 104,  816, 336, 24, 24, 4, 4,  6);
      5'd27:   ent = mk_entry(0, 120, 120, 1050, 408, 18, 18, 6, 6,  6);
      5'd28:   ent = mk_entry(0, 132, 132, 1304, 496, 20, 20, 6, 6,  8);
      5'd29:   ent = mk_entry(0, 144, 144, 1558, 620, 22, 22, 6, 6, 10);
      default: ent = '0;
    endcase
    return ent;
  endfunction

endpackage

/* rtl/dss_cell.sv */
// One search cell: tests its own table entry and passes the token on.
module dss_cell import dss_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  dss_cfg_t   cfg,
  input  logic       prev_valid,
  input  dss_token_t prev_tok,
  output logic       tok_valid,
  output dss_token_t tok
);

  localparam dss_entry_t ENT = dss_entry(IDX_W'(IDX));

  logic       shape_ok;
  logic       size_ok;
  logic       cap_ok;
  logic       valid_r;
  dss_token_t tok_r;
  dss_token_t tok_nxt;

  assign shape_ok = !((cfg.shape == SHAPE_SQUARE) && ENT.rect) &&
                    !((cfg.shape == SHAPE_RECT) && !ENT.rect);
  assign size_ok  = (ENT.width >= cfg.min_w) && (ENT.height >= cfg.min_h) &&
                    (ENT.width <= cfg.max_w) && (ENT.height <= cfg.max_h);
  assign cap_ok   = prev_tok.need <= ENT.data;

  always_comb begin
    tok_nxt = prev_tok;
    if (!prev_tok.found && shape_ok && size_ok && cap_ok) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_valid = valid_r;
  assign tok       = tok_r;

endmodule

/* rtl/datamatrix_symbol_size_select.sv */
// Top level of the Data Matrix ECC200 symbol size selector.
// Each transaction on the input carries a count of data codewords and yields exactly one
// result transaction: the first symbol size of the standard table, in table order, whose
// shape matches shape_mode, whose full width and height lie within the configured
// minimum and maximum, and whose capacity holds the count. The search runs down a
// row of SYMBOL_COUNT cells, one per table entry, and while the row is not held a
// request moves one cell per clock. The result is read from the last cell's register.
// The row is a pipeline: while the output is not stalled a new transaction is taken
// every cycle. When the output stalls, the whole row holds and the input is stalled
// with it. If no entry fits, found is 0, every geometry field is 0, and error_flag
// follows fail_on_overflow.
module datamatrix_symbol_size_select import dss_pkg::*; #(
  parameter int SYMBOL_COUNT = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] in_data_codewords,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic        out_error_flag,
  output logic [4:0]  out_symbol_index,
  output logic [7:0]  out_symbol_width,
  output logic [7:0]  out_symbol_height,
  output logic [10:0] out_data_capacity,
  output logic [9:0]  out_error_codewords,
  output logic [4:0]  out_region_width,
  output logic [4:0]  out_region_height,
  output logic [2:0]  out_horizontal_regions,
  output logic [2:0]  out_vertical_regions,
  output logic [3:0]  out_interleaved_blocks
);

  // Configuration registers.
  logic [1:0] shape_mode_r;
  logic [7:0] min_width_r;
  logic [7:0] min_height_r;
  logic [7:0] max_width_r;
  logic [7:0] max_height_r;
  logic       fail_on_overflow_r;

  logic       cfg_write;
  logic [2:0] reg_sel;
  dss_cfg_t   cfg;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r       <= SHAPE_ANY;
      min_width_r        <= 8'd0;
      min_height_r       <= 8'd0;
      max_width_r        <= 8'd144;
      max_height_r       <= 8'd144;
      fail_on_overflow_r <= 1'b1;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_SHAPE_MODE:       shape_mode_r       <= pwdata[1:0];
        REG_MIN_WIDTH:        min_width_r        <= pwdata[7:0];
        REG_MIN_HEIGHT:       min_height_r       <= pwdata[7:0];
        REG_MAX_WIDTH:        max_width_r        <= pwdata[7:0];
        REG_MAX_HEIGHT:       max_height_r       <= pwdata[7:0];
        REG_FAIL_ON_OVERFLOW: fail_on_overflow_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SHAPE_MODE:       prdata = {30'd0, shape_mode_r};
      REG_MIN_WIDTH:        prdata = {24'd0, min_width_r};
      REG_MIN_HEIGHT:       prdata = {24'd0, min_height_r};
      REG_MAX_WIDTH:        prdata = {24'd0, max_width_r};
      REG_MAX_HEIGHT:       prdata = {24'd0, max_height_r};
      REG_FAIL_ON_OVERFLOW: prdata = {31'd0, fail_on_overflow_r};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg.shape = shape_mode_r;
  assign cfg.min_w = min_width_r;
  assign cfg.min_h = min_height_r;
  assign cfg.max_w = max_width_r;
  assign cfg.max_h = max_height_r;

  // The row moves as one: it advances unless a finished result is held by the sink.
  logic advance;

  logic       chain_valid [0:SYMBOL_COUNT];
  dss_token_t chain_tok   [0:SYMBOL_COUNT];

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  assign chain_valid[0]     = in_valid;
  assign chain_tok[0].found = 1'b0;
  assign chain_tok[0].idx   = '0;
  assign chain_tok[0].need  = in_data_codewords;

  for (genvar g = 0; g < SYMBOL_COUNT; g++) begin : g_cell
    dss_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .cfg        (cfg),
      .prev_valid (chain_valid[g]),
      .prev_tok   (chain_tok[g]),
      .tok_valid  (chain_valid[g+1]),
      .tok        (chain_tok[g+1])
    );
  end

  // The last cell's register is the output register; its fields are looked up from
  // the chosen index, and a miss reads as all zeros.
  dss_token_t last_tok;
  dss_entry_t sel;

  assign last_tok  = chain_tok[SYMBOL_COUNT];
  assign out_valid = chain_valid[SYMBOL_COUNT];
  assign sel       = last_tok.found ? dss_entry(last_tok.idx) : '0;

  assign out_found              = last_tok.found;
  assign out_error_flag         = !last_tok.found && fail_on_overflow_r;
  assign out_symbol_index       = last_tok.found ? last_tok.idx : '0;
  assign out_symbol_width       = sel.width;
  assign out_symbol_height      = sel.height;
  assign out_data_capacity      = sel.data;
  assign out_error_codewords    = sel.ecc;
  assign out_region_width       = sel.rw;
  assign out_region_height      = sel.rh;
  assign out_horizontal_regions = sel.hr;
  assign out_vertical_regions   = sel.vr;
  assign out_interleaved_blocks = sel.blocks;

endmodule

/* rtl/dss_checker.sv */
// Port-level checker for the symbol size selector, bound to the top level.
`include "datamatrix_symbol_size_select_assert.svh"

module dss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic        out_error_flag,
  input logic [4:0]  out_symbol_index,
  input logic [7:0]  out_symbol_width,
  input logic [10:0] out_data_capacity
);

  // A hit never reports an error.
  `DSS_ASSERT_NOW(a_hit_no_error, out_valid && out_found, !out_error_flag,
                  "error flag raised on a found symbol")

  // A miss carries an all-zero geometry.
  `DSS_ASSERT_NOW(a_miss_zero, out_valid && !out_found,
                  (out_symbol_index == 5'd0) && (out_symbol_width == 8'd0) &&
                  (out_data_capacity == 11'd0), "miss result carries nonzero fields")

  // A held result stays on the port.
  `DSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid,
                   "result dropped while stalled")

  `DSS_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                   $stable(out_symbol_index) && $stable(out_found),
                   "result changed while stalled")

endmodule

bind datamatrix_symbol_size_select dss_checker u_dss_checker (.*);

/* tb/datamatrix_symbol_size_select_tb.sv */
// Self-checking testbench for the Data Matrix ECC200 symbol size selector.
`timescale 1ns / 100ps

module datamatrix_symbol_size_select_tb import dss_pkg::*; ();

  // The search row has one cell per table entry.
  localparam int SYMBOLS      = 30;
  localparam int ROW_LATENCY  = SYMBOLS;
  localparam int ITEM_TARGET  = 1000;
  localparam int IDLE_PERCENT = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_CAP    = 40;

  // The fourth shape code is not named in the package; the block treats it as any shape.
  localparam logic [1:0] SHAPE_UNUSED = 2'd3;

  // Column positions in the symbol table below.
  localparam int COL_RECT   = 0;
  localparam int COL_DATA   = 1;
  localparam int COL_ECC    = 2;
  localparam int COL_RW     = 3;
  localparam int COL_RH     = 4;
  localparam int COL_HR     = 5;
  localparam int COL_VR     = 6;
  localparam int COL_BLOCKS = 7;

  // One expected result transaction, field by field at the port widths.
  typedef struct packed {
    logic        found;
    logic        error_flag;
    logic [4:0]  symbol_index;
    logic [7:0]  symbol_width;
    logic [7:0]  symbol_height;
    logic [10:0] data_capacity;
    logic [9:0]  error_codewords;
    logic [4:0]  region_width;
    logic [4:0]  region_height;
    logic [2:0]  horizontal_regions;
    logic [2:0]  vertical_regions;
    logic [3:0]  interleaved_blocks;
  } sym_result_t;

  // The ECC200 size table: rectangular flag, data and error codewords, region width and
  // height, regions across and down, interleaved blocks. Full width and height are derived
  // from the regions, each of which carries a two-module border.
  int unsigned sym_geom [SYMBOLS][8] = '{
    '{0,    3,   5,  8,  8, 1, 1,  1},
    '{0,    5,   7, 10, 10, 1, 1,  1},
    '{1,    5,   7, 16,  6, 1, 1,  1},
    '{0,    8,  10, 12, 12, 1, 1,  1},
    '{1,   10,  11, 14,  6, 2, 1,  1},
    '{0,   12,  12, 14, 14, 1, 1,  1},
    '{1,   16,  14, 24, 10, 1, 1,  1},
    '{0,   18,  14, 16, 16, 1, 1,  1},
    '{0,   22,  18, 18, 18, 1, 1,  1},
    '{1,   22,  18, 16, 10, 2, 1,  1},
    '{0,   30,  20, 20, 20, 1, 1,  1},
    '{1,   32,  24, 16, 14, 2, 1,  1},
    '{0,   36,  24, 22, 22, 1, 1,  1},
    '{0,   44,  28, 24, 24, 1, 1,  1},
    '{1,   49,  28, 22, 14, 2, 1,  1},
    '{0,   62,  36, 14, 14, 2, 2,  1},
    '{0,   86,  42, 16, 16, 2, 2,  1},
    '{0,  114,  48, 18, 18, 2, 2,  1},
    '{0,  144,  56, 20, 20, 2, 2,  1},
    '{0,  174,  68, 22, 22, 2, 2,  1},
    '{0,  204,  84, 24, 24, 2, 2,  2},
    '{0,  280, 112, 14, 14, 4, 4,  2},
    '{0,  368, 144, 16, 16, 4, 4,  4},
    '{0,  456, 192, 18, 18, 4, 4,  4},
    '{0,  576, 224, 20, 20, 4, 4,  4},
    '{0,  696, 272, 22, 22, 4, 4,  4},
    '{0,  816, 336, 24, 24, 4, 4,  6},
    '{0, 1050, 408, 18, 18, 6, 6,  6},
    '{0, 1304, 496, 20, 20, 6, 6,  8},
    '{0, 1558, 620, 22, 22, 6, 6, 10}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [10:0] in_data_codewords = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic        out_error_flag;
  logic [4:0]  out_symbol_index;
  logic [7:0]  out_symbol_width;
  logic [7:0]  out_symbol_height;
  logic [10:0] out_data_capacity;
  logic [9:0]  out_error_codewords;
  logic [4:0]  out_region_width;
  logic [4:0]  out_region_height;
  logic [2:0]  out_horizontal_regions;
  logic [2:0]  out_vertical_regions;
  logic [3:0]  out_interleaved_blocks;

  // The testbench's own copy of the configuration registers, at their reset values.
  logic [1:0] cfg_shape = SHAPE_ANY;
  logic [7:0] cfg_min_w = 8'd0;
  logic [7:0] cfg_min_h = 8'd0;
  logic [7:0] cfg_max_w = 8'd144;
  logic [7:0] cfg_max_h = 8'd144;
  logic       cfg_fail  = 1'b1;

  logic [10:0] request_queue [$];
  sym_result_t selection_queue [$];

  logic in_taken = 1'b0;
  bit   burst_mode = 1'b0;
  bit   hold_armed = 1'b0;
  bit   hold_used = 1'b0;
  int   hold_left = 0;

  int mismatches = 0;
  int requests_queued = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int misses_expected = 0;
  int settings_applied = 0;

  datamatrix_symbol_size_select #(
    .SYMBOL_COUNT(SYMBOLS)
  ) DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data_codewords      (in_data_codewords),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_found              (out_found),
    .out_error_flag         (out_error_flag),
    .out_symbol_index       (out_symbol_index),
    .out_symbol_width       (out_symbol_width),
    .out_symbol_height      (out_symbol_height),
    .out_data_capacity      (out_data_capacity),
    .out_error_codewords    (out_error_codewords),
    .out_region_width       (out_region_width),
    .out_region_height      (out_region_height),
    .out_horizontal_regions (out_horizontal_regions),
    .out_vertical_regions   (out_vertical_regions),
    .out_interleaved_blocks (out_interleaved_blocks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scan the table in order and take the first entry that passes the shape test, the size
  // window and the capacity test. With nothing chosen every field stays zero except the
  // error flag, which then mirrors the fail option.
  function automatic sym_result_t pick_symbol(input logic [10:0] need);
    sym_result_t pick;
    int unsigned w;
    int unsigned h;
    bit done;
    pick = '0;
    pick.error_flag = cfg_fail;
    done = 1'b0;
    for (int i = 0; i < SYMBOLS; i++) begin
      w = sym_geom[i][COL_HR] * (sym_geom[i][COL_RW] + 2);
      h = sym_geom[i][COL_VR] * (sym_geom[i][COL_RH] + 2);
      if (done) begin
        // Already chosen; later entries do not matter.
      end else if (cfg_shape == SHAPE_SQUARE && sym_geom[i][COL_RECT] == 1) begin
      end else if (cfg_shape == SHAPE_RECT && sym_geom[i][COL_RECT] == 0) begin
      end else if (w < cfg_min_w || h < cfg_min_h || w > cfg_max_w || h > cfg_max_h) begin
      end else if (need <= sym_geom[i][COL_DATA]) begin
        done = 1'b1;
        pick.found              = 1'b1;
        pick.error_flag         = 1'b0;
        pick.symbol_index       = 5'(i);
        pick.symbol_width       = 8'(w);
        pick.symbol_height      = 8'(h);
        pick.data_capacity      = 11'(sym_geom[i][COL_DATA]);
        pick.error_codewords    = 10'(sym_geom[i][COL_ECC]);
        pick.region_width       = 5'(sym_geom[i][COL_RW]);
        pick.region_height      = 5'(sym_geom[i][COL_RH]);
        pick.horizontal_regions = 3'(sym_geom[i][COL_HR]);
        pick.vertical_regions   = 3'(sym_geom[i][COL_VR]);
        pick.interleaved_blocks = 4'(sym_geom[i][COL_BLOCKS]);
      end
    end
    return pick;
  endfunction

  // Prints one line per differing field and counts it; the printing stops after a while
  // so that a badly broken block does not flood the log.
  task automatic note_field(input string name, input logic [31:0] got,
                            input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("mismatch on %0s in result %0d: got %0d, expected %0d",
                 name, results_seen, got, want);
    end
  endtask

  // Most requests sit right at or next to a table capacity, where the choice flips from
  // one entry to the next. The rest spread over the whole field, past the largest symbol
  // included, and now and then hit the two ends of the field.
  function automatic logic [10:0] random_request();
    int roll;
    int entry;
    int count;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      entry = $urandom_range(0, SYMBOLS - 1);
      count = int'(sym_geom[entry][COL_DATA]) + int'($urandom_range(0, 2)) - 1;
    end else if (roll < 88) begin
      count = $urandom_range(0, 1600);
    end else if (roll < 96) begin
      count = $urandom_range(1559, 2047);
    end else begin
      count = ($urandom_range(0, 1) == 1) ? 2047 : 0;
    end
    return 11'(count);
  endfunction

  // Size limits mix the no-limit values, values past 144, exact table dimensions and
  // plain random bytes.
  function automatic logic [7:0] random_limit(input bit is_max);
    int roll;
    int entry;
    roll = $urandom_range(0, 99);
    entry = $urandom_range(0, SYMBOLS - 1);
    if (roll < 30)
      return is_max ? 8'd144 : 8'd0;
    else if (roll < 40)
      return 8'd255;
    else if (roll < 75)
      return 8'(sym_geom[entry][COL_HR] * (sym_geom[entry][COL_RW] + 2));
    else
      return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) begin
      request_queue.push_back(random_request());
      requests_queued++;
    end
  endtask

  // One register write: a setup phase, then an access phase that completes on the edge at
  // which pready is seen high. Bits above the register's width carry random junk, which
  // the block must ignore.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value, input int nbits);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom << nbits) | value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SHAPE_MODE:       cfg_shape = value[1:0];
      REG_MIN_WIDTH:        cfg_min_w = value[7:0];
      REG_MIN_HEIGHT:       cfg_min_h = value[7:0];
      REG_MAX_WIDTH:        cfg_max_w = value[7:0];
      REG_MAX_HEIGHT:       cfg_max_h = value[7:0];
      REG_FAIL_ON_OVERFLOW: cfg_fail  = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [1:0] shape, input logic [7:0] min_w,
                                input logic [7:0] min_h, input logic [7:0] max_w,
                                input logic [7:0] max_h, input logic fail);
    cfg_write(REG_SHAPE_MODE, 32'(shape), 2);
    cfg_write(REG_MIN_WIDTH, 32'(min_w), 8);
    cfg_write(REG_MIN_HEIGHT, 32'(min_h), 8);
    cfg_write(REG_MAX_WIDTH, 32'(max_w), 8);
    cfg_write(REG_MAX_HEIGHT, 32'(max_h), 8);
    cfg_write(REG_FAIL_ON_OVERFLOW, 32'(fail), 1);
    settings_applied++;
  endtask

  // The sender stops here until every queued request has been taken and every result
  // it caused has come back. Each request yields exactly one result, so an empty store
  // of selections means the search row is empty too.
  task automatic drain_results();
    @(posedge clk);
    while (request_queue.size() != 0 || in_valid || selection_queue.size() != 0)
      @(posedge clk);
  endtask

  // Request driver. A new transaction is offered only once the previous one was taken;
  // while the block stalls, valid and the payload stay as they are.
  always @(negedge clk) begin
    bit idle_now;
    idle_now = !burst_mode && ($urandom_range(0, 99) < IDLE_PERCENT);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_queue.size() != 0 && !idle_now) begin
        in_valid          <= 1'b1;
        in_data_codewords <= request_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver. A hold-off, once armed, keeps the output stalled while the driver
  // keeps offering requests, so the row fills and pushes back.
  always @(negedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !burst_mode && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Monitor. Every accepted request is predicted against the configuration in force;
  // every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    sym_result_t want;
    sym_result_t guess;
    if (rst_n && in_valid && !in_stall) begin
      guess = pick_symbol(in_data_codewords);
      if (!guess.found) misses_expected++;
      selection_queue.push_back(guess);
      requests_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (selection_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("result %0d arrived with no request outstanding", results_seen);
      end else begin
        want = selection_queue.pop_front();
        note_field("found", 32'(out_found), 32'(want.found));
        note_field("error_flag", 32'(out_error_flag), 32'(want.error_flag));
        note_field("symbol_index", 32'(out_symbol_index), 32'(want.symbol_index));
        note_field("symbol_width", 32'(out_symbol_width), 32'(want.symbol_width));
        note_field("symbol_height", 32'(out_symbol_height), 32'(want.symbol_height));
        note_field("data_capacity", 32'(out_data_capacity), 32'(want.data_capacity));
        note_field("error_codewords", 32'(out_error_codewords),
                   32'(want.error_codewords));
        note_field("region_width", 32'(out_region_width), 32'(want.region_width));
        note_field("region_height", 32'(out_region_height), 32'(want.region_height));
        note_field("horizontal_regions", 32'(out_horizontal_regions),
                   32'(want.horizontal_regions));
        note_field("vertical_regions", 32'(out_vertical_regions),
                   32'(want.vertical_regions));
        note_field("interleaved_blocks", 32'(out_interleaved_blocks),
                   32'(want.interleaved_blocks));
      end
      results_seen++;
    end
    in_taken <= in_valid && !in_stall;
  end

  // Main sequence: directed requests at the reset settings, a long output hold-off, a set
  // of hand-picked settings with the special limit cases, then random settings until the
  // request count is reached.
  initial begin
    logic [10:0] directed [$];
    directed = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd6, 11'd8, 11'd9,
                 11'd44, 11'd49, 11'd50, 11'd204, 11'd205, 11'd816, 11'd817, 11'd1050,
                 11'd1304, 11'd1305, 11'd1557, 11'd1558, 11'd1559, 11'd2047};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero codewords, the smallest capacities and a selection of capacity
    // boundaries, the largest symbol and requests that nothing can hold.
    foreach (directed[k]) begin
      request_queue.push_back(directed[k]);
      requests_queued++;
    end
    drain_results();

    // Long output hold-off with the sender still busy behind it.
    @(posedge clk);
    hold_armed = 1'b1;
    queue_random(150);
    drain_results();

    // Square only, rectangular only, and the unused shape code.
    apply_settings(SHAPE_SQUARE, 8'd0, 8'd0, 8'd144, 8'd144, 1'b1);
    queue_random(40);
    drain_results();
    apply_settings(SHAPE_RECT, 8'd0, 8'd0, 8'd144, 8'd144, 1'b0);
    queue_random(40);
    drain_results();
    apply_settings(SHAPE_UNUSED, 8'd0, 8'd0, 8'd144, 8'd144, 1'b1);
    queue_random(40);
    drain_results();

    // Minimums past 144 reject every entry; maximums past 144 impose no limit.
    apply_settings(SHAPE_ANY, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    queue_random(30);
    drain_results();
    apply_settings(SHAPE_ANY, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
    queue_random(40);
    drain_results();

    // Crossed limits, a window that admits only the largest symbol, one that admits only
    // the smallest, and a zero maximum.
    apply_settings(SHAPE_ANY, 8'd60, 8'd60, 8'd40, 8'd40, 1'b1);
    queue_random(30);
    drain_results();
    apply_settings(SHAPE_ANY, 8'd144, 8'd144, 8'd144, 8'd144, 1'b0);
    queue_random(40);
    drain_results();
    apply_settings(SHAPE_ANY, 8'd10, 8'd10, 8'd10, 8'd10, 1'b1);
    queue_random(30);
    drain_results();
    apply_settings(SHAPE_ANY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_random(30);
    drain_results();
    apply_settings(SHAPE_RECT, 8'd32, 8'd0, 8'd48, 8'd16, 1'b1);
    queue_random(40);
    drain_results();

    // One stretch at full rate on both sides, with no idling at all.
    apply_settings(SHAPE_ANY, 8'd0, 8'd0, 8'd144, 8'd144, 1'b1);
    burst_mode = 1'b1;
    queue_random(120);
    drain_results();
    burst_mode = 1'b0;

    while (requests_queued < ITEM_TARGET) begin
      apply_settings(2'($urandom_range(0, 3)), random_limit(1'b0), random_limit(1'b0),
                     random_limit(1'b1), random_limit(1'b1), 1'($urandom_range(0, 1)));
      queue_random(40);
      drain_results();
    end

    repeat (ROW_LATENCY + 10) @(posedge clk);

    if (selection_queue.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", selection_queue.size());
    end
    $display("Covered %0d requests under %0d register settings,",
             requests_taken, settings_applied + 1);
    $display("%0d of them with no fitting size, a %0d-cycle output hold-off and a %0s",
             misses_expected, HOLD_CYCLES, "full-rate stretch.");
    $display("%0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run, which takes well under 100 us.
  initial begin
    #2_000_000;
    $display("Run timed out with %0d results outstanding.", selection_queue.size());
    $display("FAILURE");
    $finish;
  end

endmodule
